// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/srs_pkg.sv -----
// types, codes and constants of the sharded replay index sampler
`default_nettype none

package srs_pkg;

  localparam int MAX_SHARDS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [63:0] DEFAULT_SEED = 64'h9e37_79b9_7f4a_7c15;
  localparam int XS_SHL_A = 13;
  localparam int XS_SHR   = 7;
  localparam int XS_SHL_B = 17;

  localparam int SHARDS_REG_W = 5;
  localparam int CFG_IDX_W    = 1;

  localparam logic [1:0] REQ_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] REQ_SAMPLE_GEN  = 2'd1;
  localparam logic [1:0] REQ_SAMPLE_EXT  = 2'd2;
  localparam logic [1:0] REQ_NONE        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARDS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED          = 1'd1;

  localparam logic ERR_OK    = 1'b0;
  localparam logic ERR_EMPTY = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  entry_index;
    logic [31:0] entry_total;
    logic [63:0] supplied_word;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  shard_sel;
    logic [31:0] game_local;
    logic [31:0] game_global;
    logic [31:0] step_random;
    logic [63:0] sample_word;
    logic        error_code;
  } rsp_item_t;

  // queued command between front and back
  typedef struct packed {
    logic        is_sample;
    logic [3:0]  entry_index;
    logic [31:0] entry_total;
    logic [63:0] word;
  } cmd_t;

  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x << XS_SHL_A);
    x = x ^ (x >> XS_SHR);
    x = x ^ (x << XS_SHL_B);
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/srs_fifo.sv -----
// two-entry command queue between front and back
`default_nettype none

module srs_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  srs_pkg::cmd_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output srs_pkg::cmd_t      pop_data
);
  import srs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/srs_front.sv -----
// request intake: classifies requests, runs the xorshift generator, feeds the queue
`default_nettype none

module srs_front #(
  parameter int MAX_SHARDS = srs_pkg::MAX_SHARDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  srs_pkg::cfg_wr_t   cfg,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  srs_pkg::req_item_t req,
  output logic               push,
  output srs_pkg::cmd_t      push_data,
  input  wire logic          q_full
);
  import srs_pkg::*;

  logic [63:0] gen_state;
  logic [63:0] gen_next;
  logic        accept;
  logic        idx_ok;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign gen_next  = xorshift_next(gen_state);
  assign idx_ok    = (32'(req.entry_index) < MAX_SHARDS);

  always_comb begin
    push_data.is_sample   = 1'b1;
    push_data.entry_index = req.entry_index;
    push_data.entry_total = req.entry_total;
    push_data.word        = req.supplied_word;
    push                  = 1'b0;
    case (req.req_type)
      REQ_WRITE_ENTRY: begin
        push_data.is_sample = 1'b0;
        push                = accept && idx_ok;
      end
      REQ_SAMPLE_GEN: begin
        push_data.word = gen_next;
        push           = accept;
      end
      REQ_SAMPLE_EXT: begin
        push = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= DEFAULT_SEED;
    end else if (cfg.write && cfg.index == CFG_SEED) begin
      gen_state <= (cfg.data == 64'd0) ? DEFAULT_SEED : cfg.data;
    end else if (accept && req.req_type == REQ_SAMPLE_GEN) begin
      gen_state <= gen_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/srs_divmod.sv -----
// restoring divider, one dividend bit per cycle, returns the remainder
`default_nettype none

module srs_divmod #(
  parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [63:0]            dividend,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [COUNT_WIDTH-1:0]      rem
);
  import srs_pkg::*;

  logic [63:0]            dvd;
  logic [COUNT_WIDTH-1:0] dsr;
  logic [6:0]             count;
  logic                   busy;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic [COUNT_WIDTH-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[63]};
    diff     = trial - {1'b0, dsr};
    rem_next = (trial >= {1'b0, dsr}) ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 7'd0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == 7'd1);
      if (start) begin
        busy  <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/srs_back.sv -----
// sample engine: table memory, modulo by total, linear shard scan, result register
`default_nettype none
`include "assert_macros.svh"

module srs_back #(
  parameter int MAX_SHARDS  = srs_pkg::MAX_SHARDS_DEF,
  parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  srs_pkg::cfg_wr_t   cfg,
  input  wire logic          q_valid,
  input  srs_pkg::cmd_t      q_data,
  output logic               pop,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output srs_pkg::rsp_item_t rsp
);
  import srs_pkg::*;

  localparam int IDX_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;

  back_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] table_mem [MAX_SHARDS];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  logic [SHARDS_REG_W-1:0] shards_in_use;
  logic [IDX_W-1:0]        last;

  logic [63:0]            word;
  logic [COUNT_WIDTH-1:0] global_idx;
  logic [COUNT_WIDTH-1:0] prev_entry;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       shard;
  logic [31:0]            local_idx;
  logic                   err;
  logic                   hit;
  logic                   load_rsp;

  logic                   div_start;
  logic                   div_done;
  logic [COUNT_WIDTH-1:0] div_rem;

  srs_divmod #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_divmod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (word),
    .divisor  (rd_data),
    .done     (div_done),
    .rem      (div_rem)
  );

  // clamp the shard count to 1..MAX_SHARDS
  always_comb begin
    if (shards_in_use == '0) begin
      last = '0;
    end else if (32'(shards_in_use) > MAX_SHARDS) begin
      last = IDX_W'(MAX_SHARDS - 1);
    end else begin
      last = IDX_W'(shards_in_use - SHARDS_REG_W'(1));
    end
  end

  assign hit = (rd_data > global_idx) || (scan_idx == last);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_data.is_sample) begin
          state_next = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        state_next = (rd_data == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_rsp  = 1'b0;
    rd_addr   = scan_idx + IDX_W'(1);
    case (state)
      ST_IDLE: begin
        pop     = q_valid;
        mem_we  = q_valid && !q_data.is_sample;
        rd_addr = last;
      end
      ST_TOTAL: begin
        div_start = (rd_data != '0);
      end
      ST_DIV: begin
        rd_addr = '0;
      end
      ST_DONE: begin
        load_rsp = !rsp_valid || !rsp_stall;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[IDX_W'(q_data.entry_index)] <= COUNT_WIDTH'(q_data.entry_total);
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      shards_in_use <= SHARDS_REG_W'(1);
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.write && cfg.index == CFG_SHARDS_IN_USE) begin
        shards_in_use <= cfg.data[SHARDS_REG_W-1:0];
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        word <= q_data.word;
      end
      ST_TOTAL: begin
        err <= (rd_data == '0);
      end
      ST_DIV: begin
        global_idx <= div_rem;
        scan_idx   <= '0;
        prev_entry <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          shard     <= scan_idx;
          // wraps modulo 2^32 on an unsorted table
          local_idx <= 32'(64'(global_idx) - 64'(prev_entry));
        end else begin
          scan_idx   <= scan_idx + IDX_W'(1);
          prev_entry <= rd_data;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.sample_word <= word;
      if (err) begin
        rsp.shard_sel   <= '0;
        rsp.game_local  <= '0;
        rsp.game_global <= '0;
        rsp.step_random <= '0;
        rsp.error_code  <= ERR_EMPTY;
      end else begin
        rsp.shard_sel   <= 4'(shard);
        rsp.game_local  <= local_idx;
        rsp.game_global <= 32'(global_idx);
        rsp.step_random <= word[63:32];
        rsp.error_code  <= ERR_OK;
      end
    end
  end

  `ASSERT_NEXT(a_div_follows_start, div_start, state == ST_DIV)
  `ASSERT_IMP(a_scan_in_range, state == ST_SCAN, scan_idx <= last)
  `ASSERT_IMP(a_err_fields_zero, rsp_valid && rsp.error_code == ERR_EMPTY,
              rsp.shard_sel == 4'd0 && rsp.game_global == 32'd0)
  `ASSERT_IMP(a_pop_only_idle, pop, state == ST_IDLE)

endmodule

`default_nettype wire

// ----- hdl/sharded_replay_index_sampler.sv -----
// sample request: a pop, a read of the last in-use table entry, the bit-serial remainder divider,
// a shard-table scan over up to n entries, a result load; n = shards in use
// table write request: popped and written to the table in the idle state; the queue absorbs 2 requests ahead
// the bit-serial remainder divider sets the sustained rate, one request in flight in the back
// rst (synchronous) clears the queue, state, result valid, shards_in_use to 1 and the
// generator to the default seed; table contents stay undefined until written
`default_nettype none

module sharded_replay_index_sampler #(
  parameter int MAX_SHARDS  = srs_pkg::MAX_SHARDS_DEF,
  parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                    cfg_data,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  srs_pkg::req_item_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output srs_pkg::rsp_item_t                  rsp
);
  import srs_pkg::*;

  cfg_wr_t cfg;
  cmd_t    push_data;
  cmd_t    pop_data;
  logic    push;
  logic    q_full;
  logic    q_valid;
  logic    pop;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  srs_front #(
    .MAX_SHARDS (MAX_SHARDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  srs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  srs_back #(
    .MAX_SHARDS  (MAX_SHARDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the sharded replay index sampler: random requests checked against a predictor
`default_nettype none

module testbench;
  import srs_pkg::*;

  localparam int STALE_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 100;
  localparam int HOLDOFF_LEN  = 600;
  localparam int NUM_SHARDS   = MAX_SHARDS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp;

  // predictor state
  logic [31:0] shard_totals [NUM_SHARDS];
  logic [63:0] gen_state;
  logic [4:0] shards_reg;

  req_item_t pending_reqs [$];
  rsp_item_t expected_samples [$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_pct = 33;
  int stall_pct = 33;
  int holdoff_left = 0;
  bit holdoff_used = 1'b0;

  sharded_replay_index_sampler dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  // updates the predictor state and returns 1 when the request yields a sample
  function automatic bit predict_sample(input req_item_t r, output rsp_item_t res);
    logic [63:0] word;
    logic [31:0] total, global_idx, base;
    int n, pick, i;
    res = '0;
    if (r.req_type == REQ_WRITE_ENTRY) begin
      shard_totals[r.entry_index] = r.entry_total;
      return 1'b0;
    end
    if (r.req_type == REQ_NONE) return 1'b0;
    if (r.req_type == REQ_SAMPLE_GEN) begin
      word = gen_state ^ (gen_state << XS_SHL_A);
      word = word ^ (word >> XS_SHR);
      word = word ^ (word << XS_SHL_B);
      gen_state = word;
    end else begin
      word = r.supplied_word;
    end
    n = (shards_reg == 0) ? 1 : (shards_reg > NUM_SHARDS) ? NUM_SHARDS : int'(shards_reg);
    total = shard_totals[n-1];
    res.sample_word = word;
    if (total == 0) begin
      res.error_code = ERR_EMPTY;
      return 1'b1;
    end
    global_idx = 32'(word % {32'd0, total});
    // first entry above the global index, last in-use entry as fallback
    pick = n - 1;
    for (i = n - 1; i >= 0; i--) begin
      if (shard_totals[i] > global_idx) pick = i;
    end
    base = (pick == 0) ? 32'd0 : shard_totals[pick-1];
    res.shard_sel = 4'(pick);
    res.game_local = global_idx - base;
    res.game_global = global_idx;
    res.step_random = word[63:32];
    res.error_code = ERR_OK;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_requests
    rsp_item_t predicted;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        if (predict_sample(req, predicted))
          expected_samples.insert(expected_samples.size(), predicted);
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_valid <= 1'b1;
          req <= pending_reqs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_samples
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with none expected", rsp.sample_word, '0);
      end else begin
        want = expected_samples.pop_front();
        if (rsp.shard_sel !== want.shard_sel)
          report_mismatch("shard_sel", 64'(rsp.shard_sel), 64'(want.shard_sel));
        if (rsp.game_local !== want.game_local)
          report_mismatch("game_local", 64'(rsp.game_local), 64'(want.game_local));
        if (rsp.game_global !== want.game_global)
          report_mismatch("game_global", 64'(rsp.game_global), 64'(want.game_global));
        if (rsp.step_random !== want.step_random)
          report_mismatch("step_random", 64'(rsp.step_random), 64'(want.step_random));
        if (rsp.sample_word !== want.sample_word)
          report_mismatch("sample_word", rsp.sample_word, want.sample_word);
        if (rsp.error_code !== want.error_code)
          report_mismatch("error_code", 64'(rsp.error_code), 64'(want.error_code));
      end
    end
    // one long hold-off so the request queue backs up
    if (!holdoff_used && results_seen >= 150) begin
      holdoff_used = 1'b1;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left != 0) begin
      rsp_stall <= 1'b1;
      holdoff_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < STALE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write) stale = 0;
      else stale++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic queue_req(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [31:0] total, input logic [63:0] word);
    req_item_t r;
    r.req_type = kind;
    r.entry_index = idx;
    r.entry_total = total;
    r.supplied_word = word;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SHARDS_IN_USE) shards_reg = data[4:0];
    else gen_state = (data == 64'd0) ? DEFAULT_SEED : data;
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // cumulative table with random increments, spans from nearly empty to large
  task automatic queue_sorted_table();
    logic [31:0] run_total;
    int span, i;
    span = $urandom_range(3);
    run_total = '0;
    for (i = 0; i < NUM_SHARDS; i++) begin
      case (span)
        0: run_total += $urandom_range(1);
        1: run_total += $urandom_range(20);
        2: run_total += $urandom_range(100000);
        default: run_total += $urandom_range(32'h0800_0000);
      endcase
      queue_req(REQ_WRITE_ENTRY, 4'(i), run_total, {$urandom, $urandom});
    end
  endtask

  task automatic queue_random_req();
    logic [63:0] word;
    logic [31:0] total;
    int sel;
    sel = $urandom_range(99);
    case ($urandom_range(3))
      0: word = 64'($urandom_range(300));
      1: word = {32'hffff_ffff, $urandom};
      default: word = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0: total = 32'($urandom_range(50));
      1: total = '0;
      default: total = $urandom;
    endcase
    if (sel < 20) queue_req(REQ_WRITE_ENTRY, 4'($urandom), total, word);
    else if (sel < 55) queue_req(REQ_SAMPLE_GEN, 4'($urandom), $urandom, word);
    else if (sel < 90) queue_req(REQ_SAMPLE_EXT, 4'($urandom), $urandom, word);
    else queue_req(REQ_NONE, 4'($urandom), $urandom, word);
  endtask

  initial begin : stimulus
    int phase, k;
    shards_reg = 5'd1;
    gen_state = DEFAULT_SEED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every entry written before any sample reads the table
    for (k = 0; k < NUM_SHARDS - 1; k++)
      queue_req(REQ_WRITE_ENTRY, 4'(k), 32'(10 * (k + 1)), '0);
    queue_req(REQ_WRITE_ENTRY, 4'(NUM_SHARDS - 1), 32'hffff_ffff, '1);
    queue_req(REQ_SAMPLE_GEN, '0, '0, '0);
    queue_req(REQ_SAMPLE_EXT, '1, '1, 64'd0);
    queue_req(REQ_SAMPLE_EXT, '0, '0, '1);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'h0000_0001_0000_0005);
    queue_req(REQ_NONE, '1, '1, '1);
    // empty dataset, both sample kinds
    queue_req(REQ_WRITE_ENTRY, 4'd0, 32'd0, '0);
    queue_req(REQ_SAMPLE_GEN, '0, '0, '0);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'hdead_beef_0000_0001);
    queue_req(REQ_WRITE_ENTRY, 4'd0, 32'd10, '0);
    wait_idle();

    // all shards, zero seed falls back to the default constant
    set_config(CFG_SHARDS_IN_USE, 64'd16);
    set_config(CFG_SEED, 64'd0);
    queue_req(REQ_SAMPLE_GEN, '0, '0, '0);
    queue_req(REQ_SAMPLE_EXT, '0, '0, '1);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'd155);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'd9);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'd10);
    wait_idle();
    // shard count of zero acts as one
    set_config(CFG_SHARDS_IN_USE, 64'd0);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'd23);
    wait_idle();
    // counts above the table size clamp
    set_config(CFG_SHARDS_IN_USE, 64'd31);
    set_config(CFG_SEED, '1);
    queue_req(REQ_SAMPLE_GEN, '0, '0, '0);
    queue_req(REQ_SAMPLE_GEN, '0, '0, '0);
    wait_idle();
    set_config(CFG_SHARDS_IN_USE, 64'd17);
    queue_req(REQ_SAMPLE_EXT, '0, '0, 64'd149);
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      // first phase runs with no idling on either side
      idle_pct = (phase == 0) ? 0 : 33;
      stall_pct = (phase == 0) ? 0 : 33;
      if ($urandom_range(9) < 7) set_config(CFG_SHARDS_IN_USE, 64'($urandom_range(1, 16)));
      else set_config(CFG_SHARDS_IN_USE, 64'($urandom_range(31)));
      if ($urandom_range(7) == 0) set_config(CFG_SEED, 64'd0);
      else set_config(CFG_SEED, {$urandom, $urandom});
      if ($urandom_range(4) != 0) queue_sorted_table();
      for (k = 0; k < 120; k++) queue_random_req();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
